FILE: rtl/core/ttc_pkg.sv
package ttc_pkg;

  // Field widths fixed by the interface
  localparam int unsigned DRIFT_W  = 32;
  localparam int unsigned TICK_W   = 64;
  localparam int unsigned SEC_W    = 32;
  localparam int unsigned LOAD_W   = 24;
  localparam int unsigned TPS_W    = 10;
  // Dividend of the scaled trim: drift magnitude plus half a second of ticks
  localparam int unsigned NUMER_W  = DRIFT_W + 1;

  localparam logic [LOAD_W-1:0] LOAD_MAX   = {LOAD_W{1'b1}};
  localparam logic [LOAD_W-1:0] LOAD_MIN   = LOAD_W'(1);
  localparam logic [LOAD_W-1:0] LOAD_RESET = LOAD_W'(47999);

  // Kind of trim in force, which selects the offset magnitude
  typedef enum logic [1:0] {
    TRIM_NONE,
    TRIM_UNIT,
    TRIM_SCALED
  } trim_kind_t;

  // Per-tick information carried down the pipeline
  typedef struct packed {
    logic [TICK_W-1:0] tick_count;
    logic [SEC_W-1:0]  seconds;
    logic              trim_active;
    logic              drift_taken;
    logic              trim_neg;
    trim_kind_t        kind;
  } ttc_info_t;

endpackage

FILE: rtl/core/ttc_in_if.sv
interface ttc_in_if import ttc_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [DRIFT_W-1:0] rtc_drift;

  modport source (output valid, output rtc_drift, input ready);
  modport sink   (input valid, input rtc_drift, output ready);
endinterface

FILE: rtl/core/ttc_out_if.sv
interface ttc_out_if import ttc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] tick_count;
  logic [SEC_W-1:0]  seconds;
  logic [LOAD_W-1:0] current_load;
  logic              trim_active;
  logic              drift_taken;

  modport source (output valid, output tick_count, output seconds, output current_load,
                  output trim_active, output drift_taken, input ready);
  modport sink   (input valid, input tick_count, input seconds, input current_load,
                  input trim_active, input drift_taken, output ready);
endinterface

FILE: rtl/core/ttc_state.sv
module ttc_state import ttc_pkg::*; #(
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic                 clk,
  input  logic                 rst,
  ttc_in_if.sink               drift,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ttc_info_t            out_info,
  output logic [NUMER_W-1:0]   out_numer
);

  localparam logic [TPS_W-1:0]   TPS    = TPS_W'(TICKS_PER_SECOND);
  localparam logic [DRIFT_W-1:0] TPS_WD = DRIFT_W'(TICKS_PER_SECOND);
  localparam logic [NUMER_W-1:0] HALF   = NUMER_W'(TICKS_PER_SECOND / 2);

  // Counter and trim state; it doubles as the first pipeline register
  logic [TICK_W-1:0]  tick_total, tick_total_next;
  logic [SEC_W-1:0]   second_total, second_total_next;
  logic [TPS_W-1:0]   ticks_to_second, ticks_to_second_next;
  logic [TPS_W-1:0]   trim_left, trim_left_next;
  logic               trim_neg, trim_neg_next;
  trim_kind_t         trim_kind, trim_kind_next;
  logic [NUMER_W-1:0] trim_numer, trim_numer_next;
  logic               taken, taken_next;
  logic               valid_q;

  logic               accept;
  logic [DRIFT_W-1:0] raw;
  logic [DRIFT_W-1:0] mag;

  assign drift.ready = !valid_q || out_ready;
  assign accept      = drift.valid && drift.ready;

  // Magnitude of the drift; the most negative value comes out as 2^31
  assign raw = drift.rtc_drift;
  assign mag = raw[DRIFT_W-1] ? (~raw + DRIFT_W'(1)) : raw;

  // Next state for one tick
  always_comb begin
    tick_total_next      = tick_total + TICK_W'(1);
    second_total_next    = second_total;
    ticks_to_second_next = ticks_to_second - TPS_W'(1);
    trim_left_next       = trim_left;
    trim_neg_next        = trim_neg;
    trim_kind_next       = trim_kind;
    trim_numer_next      = trim_numer;
    taken_next           = 1'b0;

    if (trim_left != '0) begin
      trim_left_next = trim_left - TPS_W'(1);
      if (trim_left == TPS_W'(1)) begin
        trim_neg_next  = 1'b0;
        trim_kind_next = TRIM_NONE;
      end
    end else begin
      taken_next = 1'b1;
      if (raw != '0) begin
        trim_neg_next = raw[DRIFT_W-1];
        if (mag < TPS_WD) begin
          trim_kind_next = TRIM_UNIT;
          trim_left_next = mag[TPS_W-1:0];
        end else begin
          trim_kind_next  = TRIM_SCALED;
          trim_left_next  = TPS - TPS_W'(1);
          trim_numer_next = {1'b0, mag} + HALF;
        end
      end
    end

    // Seconds roll over when the countdown runs out
    if (ticks_to_second == TPS_W'(1)) begin
      ticks_to_second_next = TPS;
      second_total_next    = second_total + SEC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_total      <= '0;
      second_total    <= '0;
      ticks_to_second <= TPS;
      trim_left       <= '0;
      trim_neg        <= 1'b0;
      trim_kind       <= TRIM_NONE;
      trim_numer      <= '0;
      taken           <= 1'b0;
      valid_q         <= 1'b0;
    end else begin
      if (accept) begin
        tick_total      <= tick_total_next;
        second_total    <= second_total_next;
        ticks_to_second <= ticks_to_second_next;
        trim_left       <= trim_left_next;
        trim_neg        <= trim_neg_next;
        trim_kind       <= trim_kind_next;
        trim_numer      <= trim_numer_next;
        taken           <= taken_next;
      end
      if (accept) begin
        valid_q <= 1'b1;
      end else if (out_ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid            = valid_q;
  assign out_info.tick_count  = tick_total;
  assign out_info.seconds     = second_total;
  assign out_info.trim_active = (trim_left != '0);
  assign out_info.drift_taken = taken;
  assign out_info.trim_neg    = trim_neg;
  assign out_info.kind        = trim_kind;
  assign out_numer            = trim_numer;

`ifndef SYNTHESIS
  a_tick_inc: assert property (@(posedge clk) disable iff (rst)
    accept |=> tick_total == TICK_W'($past(tick_total) + TICK_W'(1)))
    else $error("tick count did not advance by one");

  a_trim_down: assert property (@(posedge clk) disable iff (rst)
    (accept && trim_left != '0) |=> (trim_left == TPS_W'($past(trim_left) - TPS_W'(1))
                                     && !taken))
    else $error("running trim did not count down");

  a_trim_start: assert property (@(posedge clk) disable iff (rst)
    (accept && trim_left == '0 && raw != '0) |=> (trim_left != '0 && taken))
    else $error("nonzero drift did not start a trim");

  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    ticks_to_second != '0 && ticks_to_second <= TPS)
    else $error("seconds countdown out of range");
`endif

endmodule

FILE: rtl/core/ttc_div.sv
module ttc_div import ttc_pkg::*; #(
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ttc_info_t          in_info,
  input  logic [NUMER_W-1:0] in_numer,
  output logic               out_valid,
  input  logic               out_ready,
  output ttc_info_t          out_info,
  output logic [LOAD_W-1:0]  out_mag
);

  // floor(n / d) = (n * ceil(2^SHIFT / d)) >> SHIFT for n < 2^NUMER_W, d < 2^TPS_W
  localparam int unsigned SHIFT  = NUMER_W + TPS_W;
  localparam int unsigned LO_W   = 22;
  localparam int unsigned HI_W   = SHIFT - LO_W;
  localparam int unsigned PROD_W = NUMER_W + SHIFT;
  localparam logic [SHIFT-1:0] RECIP =
    SHIFT'(((64'd1 << SHIFT) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND));

  logic                      a_valid, b_valid;
  logic                      a_ready, b_ready;
  ttc_info_t                 a_info, b_info;
  logic [NUMER_W+LO_W-1:0]   p_lo;
  logic [NUMER_W+HI_W-1:0]   p_hi;
  logic [PROD_W-1:0]         prod;
  logic [NUMER_W-1:0]        quot;
  logic [LOAD_W-1:0]         sat_q;
  logic [LOAD_W-1:0]         mag_next;
  logic [LOAD_W-1:0]         b_mag;

  assign b_ready  = !b_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // Stage A: two partial products of the reciprocal multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_info <= in_info;
      p_lo   <= in_numer * RECIP[LO_W-1:0];
      p_hi   <= in_numer * RECIP[SHIFT-1:LO_W];
    end
  end

  // Stage B: combine, take the quotient and pick the offset magnitude
  assign prod  = {p_hi, {LO_W{1'b0}}} + PROD_W'(p_lo);
  assign quot  = prod[PROD_W-1:SHIFT];
  assign sat_q = (quot > NUMER_W'(LOAD_MAX)) ? LOAD_MAX : quot[LOAD_W-1:0];

  always_comb begin
    case (a_info.kind)
      TRIM_UNIT:   mag_next = LOAD_W'(1);
      TRIM_SCALED: mag_next = sat_q;
      default:     mag_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_info <= a_info;
      b_mag  <= mag_next;
    end
  end

  assign out_valid = b_valid;
  assign out_info  = b_info;
  assign out_mag   = b_mag;

endmodule

FILE: rtl/core/ttc_load.sv
module ttc_load import ttc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [LOAD_W-1:0] load_base,
  input  logic              in_valid,
  output logic              in_ready,
  input  ttc_info_t         in_info,
  input  logic [LOAD_W-1:0] in_mag,
  ttc_out_if.source         result
);

  logic [LOAD_W:0]   sum;
  logic [LOAD_W-1:0] load_next;

  assign in_ready = !result.valid || result.ready;

  // Base plus signed offset, clamped to the legal reload range
  assign sum = {1'b0, load_base} + {1'b0, in_mag};

  always_comb begin
    if (in_info.trim_neg) begin
      load_next = (in_mag >= load_base) ? LOAD_MIN : (load_base - in_mag);
    end else if (sum[LOAD_W]) begin
      load_next = LOAD_MAX;
    end else if (sum[LOAD_W-1:0] == '0) begin
      load_next = LOAD_MIN;
    end else begin
      load_next = sum[LOAD_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (in_ready) begin
      result.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      result.tick_count   <= in_info.tick_count;
      result.seconds      <= in_info.seconds;
      result.current_load <= load_next;
      result.trim_active  <= in_info.trim_active;
      result.drift_taken  <= in_info.drift_taken;
    end
  end

endmodule

FILE: rtl/core/trimmed_tick_clock.sv
// System tick counter with reload trim against a stable RTC.
// Input channel (drift): one transaction per system tick, carrying the
// signed drift seen against the RTC; it is only looked at on ticks where
// no trim is running. Output channel (result): one transaction per tick
// with the tick count, whole seconds, the trimmed reload value
// (1..2^24-1), the trim flag and whether this tick used the drift.
// cfg_wr_en/cfg_wr_data write load_base, the untrimmed reload; write it
// only while no tick is in flight. Changes apply to later results.
// The result is registered after the state update, the split reciprocal
// multiply and the load add and clamp. Throughput is one tick per cycle while
// the receiver keeps result.ready high; the two-stage multiply for the scaled
// trim offset sets the depth.
// Reset (synchronous, rst high) clears the counters and any trim, reloads
// the seconds countdown and sets load_base to 47999.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// drops drift.ready only once every stage holds a tick; nothing is lost.
module trimmed_tick_clock import ttc_pkg::*; #(
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [LOAD_W-1:0] cfg_wr_data,
  ttc_in_if.sink            drift,
  ttc_out_if.source         result
);

  logic               s_valid, s_ready;
  ttc_info_t          s_info;
  logic [NUMER_W-1:0] s_numer;
  logic               d_valid, d_ready;
  ttc_info_t          d_info;
  logic [LOAD_W-1:0]  d_mag;
  logic [LOAD_W-1:0]  load_base;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      load_base <= LOAD_RESET;
    end else if (cfg_wr_en) begin
      load_base <= cfg_wr_data;
    end
  end

  ttc_state #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_state (
    .clk       (clk),
    .rst       (rst),
    .drift     (drift),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_info  (s_info),
    .out_numer (s_numer)
  );

  ttc_div #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_info   (s_info),
    .in_numer  (s_numer),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_info  (d_info),
    .out_mag   (d_mag)
  );

  ttc_load u_load (
    .clk       (clk),
    .rst       (rst),
    .load_base (load_base),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_info   (d_info),
    .in_mag    (d_mag),
    .result    (result)
  );

endmodule

FILE: tb/tb_trimmed_tick_clock.sv
module tb_trimmed_tick_clock;
  import ttc_pkg::*;

  localparam int unsigned TPS         = 1000;
  localparam int unsigned CYCLE_LIMIT = 200_000;

  // One tick result as seen on the result channel
  typedef struct packed {
    logic [TICK_W-1:0] tick_count;
    logic [SEC_W-1:0]  seconds;
    logic [LOAD_W-1:0] current_load;
    logic              trim_active;
    logic              drift_taken;
  } tick_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [LOAD_W-1:0] cfg_wr_data;

  ttc_in_if  drift_if ();
  ttc_out_if result_if ();

  trimmed_tick_clock #(
    .TICKS_PER_SECOND(TPS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .drift      (drift_if),
    .result     (result_if)
  );

  // Clock tick model state, mirrors the block after every accepted transaction
  logic [TICK_W-1:0] ticks_done    = '0;
  logic [SEC_W-1:0]  secs_done     = '0;
  int unsigned       sec_countdown = TPS;
  int unsigned       trim_left     = 0;
  bit                trim_neg      = 1'b0;
  logic [LOAD_W-1:0] trim_mag      = '0;
  logic [LOAD_W-1:0] base_load     = LOAD_RESET;

  tick_result_t pending_ticks[$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_cnt  = 0;
  bit           idle_on    = 1'b1;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[trimmed_tick_clock] ERROR");
    $finish;
  end

  // Reload value in force: base plus signed offset, clamped to 1..LOAD_MAX
  function automatic logic [LOAD_W-1:0] trimmed_load();
    logic [LOAD_W:0] sum;
    if (trim_neg) begin
      if (trim_mag >= base_load) sum = {1'b0, LOAD_MIN};
      else sum = {1'b0, base_load - trim_mag};
    end else begin
      sum = {1'b0, base_load} + {1'b0, trim_mag};
    end
    if (sum > {1'b0, LOAD_MAX}) sum = {1'b0, LOAD_MAX};
    if (sum == '0) sum = {1'b0, LOAD_MIN};
    return sum[LOAD_W-1:0];
  endfunction

  // Advance the model by one tick and return the result it should give
  function automatic tick_result_t advance_tick(input logic signed [DRIFT_W-1:0] d);
    tick_result_t    r;
    logic [DRIFT_W:0] mag;
    longint unsigned q;
    r.drift_taken = 1'b0;
    ticks_done    = ticks_done + TICK_W'(1);
    if (trim_left > 0) begin
      trim_left--;
      if (trim_left == 0) begin
        trim_neg = 1'b0;
        trim_mag = '0;
      end
    end else begin
      r.drift_taken = 1'b1;
      if (d != 0) begin
        // magnitude in one extra bit so the most negative drift is exact
        mag      = d[DRIFT_W-1] ? ({(DRIFT_W+1){1'b0}} - {d[DRIFT_W-1], d}) : {1'b0, d};
        trim_neg = d[DRIFT_W-1];
        if (mag < TPS) begin
          trim_mag  = LOAD_W'(1);
          trim_left = 32'(mag);
        end else begin
          q = (64'(mag) + TPS / 2) / TPS;
          if (q > LOAD_MAX) q = LOAD_MAX;
          trim_mag  = q[LOAD_W-1:0];
          trim_left = TPS - 1;
        end
      end
    end
    sec_countdown--;
    if (sec_countdown == 0) begin
      secs_done     = secs_done + SEC_W'(1);
      sec_countdown = TPS;
    end
    r.tick_count   = ticks_done;
    r.seconds      = secs_done;
    r.current_load = trimmed_load();
    r.trim_active  = (trim_left != 0);
    return r;
  endfunction

  // Send one tick transaction, with an occasional gap before it
  task automatic send_tick(input logic signed [DRIFT_W-1:0] d);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 17);
      drift_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    drift_if.valid     <= 1'b1;
    drift_if.rtc_drift <= d;
    @(posedge clk);
    while (!drift_if.ready) @(posedge clk);
    pending_ticks.push_back(advance_tick(d));
  endtask

  // Tick through any running trim with noise, then present a drift that is sampled
  task automatic take_drift(input logic signed [DRIFT_W-1:0] d);
    while (trim_left != 0) send_tick($urandom);
    send_tick(d);
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic drain();
    drift_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic write_load(input logic [LOAD_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    base_load = v;
    @(posedge clk);
  endtask

  // Short unit trims of either sign, with some zeros
  function automatic logic signed [DRIFT_W-1:0] rand_drift();
    logic signed [DRIFT_W-1:0] d;
    if ($urandom_range(0, 7) == 0) d = '0;
    else d = DRIFT_W'($urandom_range(1, 15));
    if ($urandom_range(0, 1) == 1) d = -d;
    return d;
  endfunction

  function automatic logic [LOAD_W-1:0] rand_base();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return LOAD_MIN;
      2:       return LOAD_MAX;
      default: return LOAD_W'($urandom);
    endcase
  endfunction

  // Receiver: ready with random stall bursts while idling is enabled
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Result checker: each transaction against the oldest expected tick
  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      got.tick_count   = result_if.tick_count;
      got.seconds      = result_if.seconds;
      got.current_load = result_if.current_load;
      got.trim_active  = result_if.trim_active;
      got.drift_taken  = result_if.drift_taken;
      if (pending_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: tick=%0d sec=%0d load=%0d trim=%0b taken=%0b",
                   got.tick_count, got.seconds, got.current_load, got.trim_active,
                   got.drift_taken);
      end else begin
        want = pending_ticks.pop_front();
        if (got.tick_count !== want.tick_count || got.seconds !== want.seconds ||
            got.current_load !== want.current_load ||
            got.trim_active !== want.trim_active || got.drift_taken !== want.drift_taken) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                     want.tick_count, want.seconds, want.current_load, want.trim_active,
                     want.drift_taken, got.tick_count, got.seconds, got.current_load,
                     got.trim_active, got.drift_taken);
        end
      end
    end
  end

  // First ticks after reset: zero drift leaves the reset reload alone
  task automatic test_first_tick();
    take_drift(0);
    take_drift(0);
  endtask

  // Drift under a second of ticks: offset of one for |drift| ticks
  task automatic test_unit_trim();
    take_drift(1);
    take_drift(-1);
    take_drift(7);
    take_drift(-15);
  endtask

  // Reload clamping at both ends, zero base, and a base change while a trim runs
  task automatic test_reload_limits();
    write_load(LOAD_MIN);
    take_drift(-2);
    write_load('0);
    take_drift(0);
    take_drift(3);
    write_load(LOAD_MAX - 1);
    take_drift(1);
    write_load(LOAD_MAX);
    take_drift(2);
    // new base takes effect part way through a trim
    take_drift(5);
    drain();
    write_load(24'd1000);
    take_drift(0);
    write_load(LOAD_RESET);
  endtask

  // Random drift stream with periodic drains and base rewrites
  task automatic test_random_ticks(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 8 == 7) drain();
      if (i % 10 == 9) write_load(rand_base());
      take_drift(rand_drift());
    end
  endtask

  // Larger drift: most negative value taken exactly, then a half rounded up;
  // the wait in between crosses the first whole second
  task automatic test_scaled_trim();
    take_drift(32'h8000_0000);
    take_drift(TPS + TPS / 2);
  endtask

  // Final stretch at full rate on both sides, while the last trim runs
  task automatic test_flat_out(input int unsigned n);
    idle_on = 1'b0;
    for (int unsigned i = 0; i < n; i++) send_tick(rand_drift());
  endtask

  // Main sequence
  initial begin
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    drift_if.valid     <= 1'b0;
    drift_if.rtc_drift <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_tick();
    test_unit_trim();
    test_reload_limits();
    test_random_ticks(30);
    test_scaled_trim();
    test_flat_out(60);

    drift_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_ticks.size() == 0)
      $display("[trimmed_tick_clock] OK");
    else
      $display("[trimmed_tick_clock] ERROR");
    $finish;
  end

endmodule
